// ===== rtl/mmpt_pkg.sv =====
// Package with the shared constants, codes and types of the min/max priority table.
package mmpt_pkg;

   localparam int CAPACITY   = 64;
   localparam int ID_BITS    = 16;
   localparam int LEVEL_BITS = 8;

   localparam int SLOT_BITS  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int ENTRY_BITS = ID_BITS + LEVEL_BITS;

   localparam int FUNC_BITS      = 2;
   localparam int REQ_ID_BITS    = 16;
   localparam int REQ_LEVEL_BITS = 8;
   localparam int ANSWER_BITS    = 16;
   localparam int STATUS_BITS    = 2;

   typedef enum logic [FUNC_BITS-1:0] {
      FUNC_ADD     = 2'd0,
      FUNC_REMOVE  = 2'd1,
      FUNC_HARDEST = 2'd2,
      FUNC_EASIEST = 2'd3
   } func_type;

   typedef enum logic [STATUS_BITS-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      logic better;
      logic match;
   } cmp_result_type;

endpackage

// ===== rtl/mmpt_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
module mmpt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/mmpt_cmp.sv =====
// Shared compare unit: orders one table entry against the running best and matches its id.
module mmpt_cmp (
   input  logic [mmpt_pkg::ID_BITS-1:0]    entry_id,
   input  logic [mmpt_pkg::LEVEL_BITS-1:0] entry_level,
   input  logic [mmpt_pkg::ID_BITS-1:0]    best_id,
   input  logic [mmpt_pkg::LEVEL_BITS-1:0] best_level,
   input  logic [mmpt_pkg::ID_BITS-1:0]    key_id,
   input  logic                            hardest,
   output mmpt_pkg::cmp_result_type        result
);

   logic level_gt;
   logic level_lt;
   logic level_eq;
   logic id_gt;
   logic id_lt;

   always_comb begin
      level_gt = entry_level > best_level;
      level_lt = entry_level < best_level;
      level_eq = entry_level == best_level;
      id_gt    = entry_id > best_id;
      id_lt    = entry_id < best_id;
      if (hardest) begin
         result.better = level_gt || (level_eq && id_gt);
      end else begin
         result.better = level_lt || (level_eq && id_lt);
      end
      result.match = entry_id == key_id;
   end

endmodule

// ===== rtl/min_max_priority_table.sv =====
// Top level of the min/max priority table: sequencer, valid bits and slot scan.
//
// Every item (add, remove, query hardest, query easiest) scans all CAPACITY slots once
// through the slot RAM and the shared compare unit, one slot per cycle, and then applies
// its update and reports one result. An accepted item passes through the scan state,
// the drain state for the last registered read and the apply state, which applies the
// update and registers the result strobe. Busy falls with the strobe, so the next item
// can be accepted at the edge that ends the strobe; a new item is not taken while busy.
// The result is shown on the rsp_ ports for exactly one cycle and must be captured
// then; the receiver cannot hold it. The table is empty after reset and needs no
// clearing time.
module min_max_priority_table (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [mmpt_pkg::FUNC_BITS-1:0]      req_func,
   input  logic [mmpt_pkg::REQ_ID_BITS-1:0]    req_item_id,
   input  logic [mmpt_pkg::REQ_LEVEL_BITS-1:0] req_level,
   output logic                                rsp_strobe,
   output logic [mmpt_pkg::ANSWER_BITS-1:0]    rsp_answer_id,
   output logic [mmpt_pkg::STATUS_BITS-1:0]    rsp_status
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_DRAIN,
      S_APPLY
   } state_type;

   state_type                         state_ff, state_in;
   logic [mmpt_pkg::CAPACITY-1:0]     slot_valid_ff, slot_valid_in;
   logic [mmpt_pkg::SLOT_BITS-1:0]    addr_ff, addr_in;
   logic                              eval_ff, eval_in;
   logic [mmpt_pkg::SLOT_BITS-1:0]    eval_idx_ff, eval_idx_in;
   mmpt_pkg::func_type                func_ff, func_in;
   logic [mmpt_pkg::ID_BITS-1:0]      key_id_ff, key_id_in;
   logic [mmpt_pkg::LEVEL_BITS-1:0]   key_level_ff, key_level_in;
   logic                              match_found_ff, match_found_in;
   logic [mmpt_pkg::SLOT_BITS-1:0]    match_idx_ff, match_idx_in;
   logic                              free_found_ff, free_found_in;
   logic [mmpt_pkg::SLOT_BITS-1:0]    free_idx_ff, free_idx_in;
   logic                              best_found_ff, best_found_in;
   logic [mmpt_pkg::ID_BITS-1:0]      best_id_ff, best_id_in;
   logic [mmpt_pkg::LEVEL_BITS-1:0]   best_level_ff, best_level_in;
   logic                              rsp_strobe_ff, rsp_strobe_in;
   logic [mmpt_pkg::ANSWER_BITS-1:0]  rsp_answer_id_ff, rsp_answer_id_in;
   mmpt_pkg::status_type              rsp_status_ff, rsp_status_in;

   logic                              ram_wr_en;
   logic [mmpt_pkg::SLOT_BITS-1:0]    ram_wr_addr;
   logic [mmpt_pkg::ENTRY_BITS-1:0]   ram_wr_data;
   logic                              ram_rd_en;
   logic [mmpt_pkg::ENTRY_BITS-1:0]   ram_rd_data;
   logic [mmpt_pkg::ID_BITS-1:0]      entry_id;
   logic [mmpt_pkg::LEVEL_BITS-1:0]   entry_level;
   logic                              entry_valid;
   logic                              hardest;
   mmpt_pkg::cmp_result_type          cmp_result;

   assign entry_id    = ram_rd_data[mmpt_pkg::ENTRY_BITS-1:mmpt_pkg::LEVEL_BITS];
   assign entry_level = ram_rd_data[mmpt_pkg::LEVEL_BITS-1:0];
   assign entry_valid = slot_valid_ff[eval_idx_ff];
   assign hardest     = func_ff == mmpt_pkg::FUNC_HARDEST;

   mmpt_ram #(
      .WIDTH (mmpt_pkg::ENTRY_BITS),
      .DEPTH (mmpt_pkg::CAPACITY)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (addr_ff),
      .rd_data (ram_rd_data)
   );

   mmpt_cmp u_cmp (
      .entry_id    (entry_id),
      .entry_level (entry_level),
      .best_id     (best_id_ff),
      .best_level  (best_level_ff),
      .key_id      (key_id_ff),
      .hardest     (hardest),
      .result      (cmp_result)
   );

   always_comb begin
      state_in         = state_ff;
      slot_valid_in    = slot_valid_ff;
      addr_in          = addr_ff;
      eval_in          = 1'b0;
      eval_idx_in      = addr_ff;
      func_in          = func_ff;
      key_id_in        = key_id_ff;
      key_level_in     = key_level_ff;
      match_found_in   = match_found_ff;
      match_idx_in     = match_idx_ff;
      free_found_in    = free_found_ff;
      free_idx_in      = free_idx_ff;
      best_found_in    = best_found_ff;
      best_id_in       = best_id_ff;
      best_level_in    = best_level_ff;
      rsp_strobe_in    = 1'b0;
      rsp_answer_id_in = rsp_answer_id_ff;
      rsp_status_in    = rsp_status_ff;
      ram_wr_en        = 1'b0;
      ram_wr_addr      = match_found_ff ? match_idx_ff : free_idx_ff;
      ram_wr_data      = {key_id_ff, key_level_ff};
      ram_rd_en        = 1'b0;

      if (eval_ff) begin
         if (entry_valid) begin
            if (cmp_result.match && !match_found_ff) begin
               match_found_in = 1'b1;
               match_idx_in   = eval_idx_ff;
            end
            if (!best_found_ff || cmp_result.better) begin
               best_found_in = 1'b1;
               best_id_in    = entry_id;
               best_level_in = entry_level;
            end
         end else if (!free_found_ff) begin
            free_found_in = 1'b1;
            free_idx_in   = eval_idx_ff;
         end
      end

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               func_in        = mmpt_pkg::func_type'(req_func);
               key_id_in      = mmpt_pkg::ID_BITS'(req_item_id);
               key_level_in   = mmpt_pkg::LEVEL_BITS'(req_level);
               match_found_in = 1'b0;
               free_found_in  = 1'b0;
               best_found_in  = 1'b0;
               addr_in        = '0;
               state_in       = S_SCAN;
            end
         end
         S_SCAN: begin
            ram_rd_en = 1'b1;
            eval_in   = 1'b1;
            addr_in   = addr_ff + 1'b1;
            if (addr_ff == mmpt_pkg::SLOT_BITS'(mmpt_pkg::CAPACITY - 1)) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_APPLY;
         end
         S_APPLY: begin
            rsp_strobe_in    = 1'b1;
            rsp_answer_id_in = '0;
            rsp_status_in    = mmpt_pkg::STATUS_OK;
            case (func_ff)
               mmpt_pkg::FUNC_ADD: begin
                  if (match_found_ff) begin
                     ram_wr_en = 1'b1;
                  end else if (free_found_ff) begin
                     ram_wr_en                  = 1'b1;
                     slot_valid_in[free_idx_ff] = 1'b1;
                  end else begin
                     rsp_status_in = mmpt_pkg::STATUS_FULL;
                  end
               end
               mmpt_pkg::FUNC_REMOVE: begin
                  if (match_found_ff) begin
                     slot_valid_in[match_idx_ff] = 1'b0;
                  end
               end
               default: begin
                  if (best_found_ff) begin
                     rsp_answer_id_in = mmpt_pkg::ANSWER_BITS'(best_id_ff);
                  end else begin
                     rsp_status_in = mmpt_pkg::STATUS_EMPTY;
                  end
               end
            endcase
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         slot_valid_ff <= '0;
         eval_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         slot_valid_ff <= slot_valid_in;
         eval_ff       <= eval_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      addr_ff          <= addr_in;
      eval_idx_ff      <= eval_idx_in;
      func_ff          <= func_in;
      key_id_ff        <= key_id_in;
      key_level_ff     <= key_level_in;
      match_found_ff   <= match_found_in;
      match_idx_ff     <= match_idx_in;
      free_found_ff    <= free_found_in;
      free_idx_ff      <= free_idx_in;
      best_found_ff    <= best_found_in;
      best_id_ff       <= best_id_in;
      best_level_ff    <= best_level_in;
      rsp_answer_id_ff <= rsp_answer_id_in;
      rsp_status_ff    <= rsp_status_in;
   end

   assign busy          = state_ff != S_IDLE;
   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_answer_id = rsp_answer_id_ff;
   assign rsp_status    = rsp_status_ff;

`ifndef SYNTHESIS
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("Result strobe lasted more than one cycle.");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("Accepted item did not make the block busy.");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status == mmpt_pkg::STATUS_EMPTY) |-> rsp_answer_id == '0)
      else $error("Empty query returned a nonzero id.");

   a_full_all_valid: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status == mmpt_pkg::STATUS_FULL) |-> (&slot_valid_ff))
      else $error("Full status reported while a slot was free.");
`endif

endmodule
